>>> hdl/ctpg_pkg.sv
// Shared types and constants for the cascaded timebase pulse generator.
// Used by every module under hdl/; depends on nothing else.
package ctpg_pkg;

  // Base tick spacing in microseconds
  localparam logic [31:0] BASE_TICK_US = 32'd2500;

  // Programmable timers in use (one to three)
  localparam int CUSTOM_TIMERS = 3;
  localparam int NUM_TIMERS    = 3;

  localparam int NOW_W       = 32;
  localparam int PERIOD_W    = 14;
  localparam int RATE_W      = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Terminal counts of the cascade counters (limit minus one)
  localparam logic [5:0] C100MS_LAST = 6'd39;
  localparam logic [6:0] C250MS_LAST = 7'd99;
  localparam logic [3:0] C1S_LAST    = 4'd9;
  localparam logic [2:0] C5S_LAST    = 3'd4;
  localparam logic [5:0] C1MIN_LAST  = 6'd59;
  localparam logic [8:0] C5MIN_LAST  = 9'd299;

  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_A = 2'd0,
    CFG_TIMER_B = 2'd1,
    CFG_TIMER_C = 2'd2
  } cfg_reg_t;

  // Control between the timebase and the programmable timers
  typedef struct packed {
    logic step;   // a poll is processed this cycle
    logic base;   // that poll produced a base tick
  } ctpg_ctl_t;

  // Timebase part of one result word
  typedef struct packed {
    logic              tick_base;
    logic              tick_100ms;
    logic              tick_250ms;
    logic              tick_1s;
    logic              toggle_1s;
    logic              tick_5s;
    logic              tick_1min;
    logic              tick_5min;
    logic [RATE_W-1:0] polls_per_second;
  } ctpg_pulse_t;

endpackage

>>> hdl/cascaded_timebase_pulse_generator_unit.sv
// Top level of the cascaded timebase pulse generator.
// Depends on ctpg_pkg, ctpg_in_reg, ctpg_timebase, ctpg_timers, ctpg_out_reg.
//
// Each input word is one poll carrying a 32-bit microsecond timestamp; each
// poll yields exactly one result word. One poll is taken every clock: the
// input register and the result register form a two-stage pipe whose only
// loops are the timebase and timer state updates, a 32-bit subtract and
// compares plus small counter increments. A stall on the result side holds
// both stages and drops in_tready. Timer periods must be written through the
// cfg port while no poll is in flight; the block does not enforce this.
module cascaded_timebase_pulse_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [31:0] now_us
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ctpg_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: [0] tick_base, [1] tick_100ms, [2] tick_250ms, [3] tick_1s,
  // [4] toggle_1s, [5] tick_5s, [6] tick_1min, [7] tick_5min,
  // [31:8] polls_per_second, [32] timer_a_due, [33] timer_b_due,
  // [34] timer_c_due, [39:35] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ctpg_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [ctpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctpg_pkg::PERIOD_W-1:0]      cfg_wdata
);

  logic                              advance;
  logic                              step;
  logic [ctpg_pkg::NOW_W-1:0]        now_us;
  ctpg_pkg::ctpg_ctl_t               ctl;
  ctpg_pkg::ctpg_pulse_t             pulse;
  logic [ctpg_pkg::NUM_TIMERS-1:0]   due;

  ctpg_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .step      (step),
    .now_us    (now_us)
  );

  ctpg_timebase u_timebase (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .now_us (now_us),
    .ctl    (ctl),
    .pulse  (pulse)
  );

  ctpg_timers u_timers (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .due       (due)
  );

  ctpg_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (step),
    .pulse      (pulse),
    .due        (due),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> hdl/ctpg_in_reg.sv
// Input register of the poll stream and the stall control of the pipe.
// Depends on ctpg_pkg.
module ctpg_in_reg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ctpg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             advance,
  output logic                             step,
  output logic [ctpg_pkg::NOW_W-1:0]       now_us
);

  logic                        in_valid_r;
  logic [ctpg_pkg::NOW_W-1:0]  now_r;

  // Take a word when empty or when the held one moves on this cycle
  assign in_tready = !in_valid_r || advance;
  assign step      = in_valid_r && advance;
  assign now_us    = now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      now_r <= in_tdata[ctpg_pkg::NOW_W-1:0];
    end
  end

endmodule

>>> hdl/ctpg_timebase.sv
// Base tick detection, cascade counters, 1 s toggle and poll rate counter.
// Depends on ctpg_pkg.
module ctpg_timebase (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [ctpg_pkg::NOW_W-1:0]  now_us,
  output ctpg_pkg::ctpg_ctl_t         ctl,
  output ctpg_pkg::ctpg_pulse_t       pulse
);

  logic [ctpg_pkg::NOW_W-1:0]  last_stamp_r, last_stamp_nxt;
  logic [5:0]                  c100_r, c100_nxt;
  logic [6:0]                  c250_r, c250_nxt;
  logic [3:0]                  c1s_r, c1s_nxt;
  logic [2:0]                  c5s_r, c5s_nxt;
  logic [5:0]                  c1min_r, c1min_nxt;
  logic [8:0]                  c5min_r, c5min_nxt;
  logic                        toggle_r, toggle_nxt;
  logic [ctpg_pkg::RATE_W-1:0] poll_cnt_r, poll_cnt_nxt;
  logic [ctpg_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic [ctpg_pkg::RATE_W-1:0] poll_inc;
  logic [ctpg_pkg::NOW_W-1:0]  elapsed;
  logic                        base;
  logic                        t100, t250, t1s, t5s, t1min, t5min;

  // Detect a base tick: enough time gone by, or the timestamp went back
  assign elapsed = now_us - last_stamp_r;
  assign base    = (elapsed >= ctpg_pkg::BASE_TICK_US) || (now_us < last_stamp_r);

  assign ctl.step = step;
  assign ctl.base = step && base;

  // Advance the cascade
  always_comb begin
    last_stamp_nxt = last_stamp_r;
    c100_nxt       = c100_r;
    c250_nxt       = c250_r;
    c1s_nxt        = c1s_r;
    c5s_nxt        = c5s_r;
    c1min_nxt      = c1min_r;
    c5min_nxt      = c5min_r;
    toggle_nxt     = toggle_r;
    rate_nxt       = rate_r;
    t100           = 1'b0;
    t250           = 1'b0;
    t1s            = 1'b0;
    t5s            = 1'b0;
    t1min          = 1'b0;
    t5min          = 1'b0;

    poll_inc     = (poll_cnt_r == ctpg_pkg::RATE_MAX) ? poll_cnt_r : poll_cnt_r + 1'b1;
    poll_cnt_nxt = poll_inc;

    if (ctl.base) begin
      last_stamp_nxt = now_us;
      t100           = (c100_r == ctpg_pkg::C100MS_LAST);
      c100_nxt       = t100 ? '0 : c100_r + 1'b1;
      t250           = (c250_r == ctpg_pkg::C250MS_LAST);
      c250_nxt       = t250 ? '0 : c250_r + 1'b1;
      if (t100) begin
        t1s     = (c1s_r == ctpg_pkg::C1S_LAST);
        c1s_nxt = t1s ? '0 : c1s_r + 1'b1;
      end
      if (t1s) begin
        toggle_nxt   = !toggle_r;
        rate_nxt     = poll_inc;
        poll_cnt_nxt = '0;
        t5s          = (c5s_r == ctpg_pkg::C5S_LAST);
        c5s_nxt      = t5s ? '0 : c5s_r + 1'b1;
        t1min        = (c1min_r == ctpg_pkg::C1MIN_LAST);
        c1min_nxt    = t1min ? '0 : c1min_r + 1'b1;
        t5min        = (c5min_r == ctpg_pkg::C5MIN_LAST);
        c5min_nxt    = t5min ? '0 : c5min_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      c100_r       <= '0;
      c250_r       <= '0;
      c1s_r        <= '0;
      c5s_r        <= '0;
      c1min_r      <= '0;
      c5min_r      <= '0;
      toggle_r     <= 1'b0;
      poll_cnt_r   <= '0;
      rate_r       <= '0;
    end else if (step) begin
      last_stamp_r <= last_stamp_nxt;
      c100_r       <= c100_nxt;
      c250_r       <= c250_nxt;
      c1s_r        <= c1s_nxt;
      c5s_r        <= c5s_nxt;
      c1min_r      <= c1min_nxt;
      c5min_r      <= c5min_nxt;
      toggle_r     <= toggle_nxt;
      poll_cnt_r   <= poll_cnt_nxt;
      rate_r       <= rate_nxt;
    end
  end

  // Values as they stand after this poll
  assign pulse.tick_base        = ctl.base;
  assign pulse.tick_100ms       = t100;
  assign pulse.tick_250ms       = t250;
  assign pulse.tick_1s          = t1s;
  assign pulse.toggle_1s        = toggle_nxt;
  assign pulse.tick_5s          = t5s;
  assign pulse.tick_1min        = t1min;
  assign pulse.tick_5min        = t5min;
  assign pulse.polls_per_second = rate_nxt;

  a_c100_bound: assert property (@(posedge clk) disable iff (!rst_n)
    c100_r <= ctpg_pkg::C100MS_LAST && c5min_r <= ctpg_pkg::C5MIN_LAST)
    else $error("cascade counter beyond its terminal count");

  a_stamp_load: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.base |=> last_stamp_r == $past(now_us))
    else $error("base tick did not load the timestamp");

  a_toggle_on_1s: assert property (@(posedge clk) disable iff (!rst_n)
    (step && t1s) |=> toggle_r != $past(toggle_r) && poll_cnt_r == '0)
    else $error("second pulse did not flip toggle and clear poll count");

endmodule

>>> hdl/ctpg_timers.sv
// Period registers and the chain of programmable base-tick timers.
// Depends on ctpg_pkg.
module ctpg_timers (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ctpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ctpg_pkg::PERIOD_W-1:0]       cfg_wdata,
  input  ctpg_pkg::ctpg_ctl_t                 ctl,
  output logic [ctpg_pkg::NUM_TIMERS-1:0]     due
);

  logic [ctpg_pkg::PERIOD_W-1:0] period_r [ctpg_pkg::NUM_TIMERS];
  logic [ctpg_pkg::PERIOD_W-1:0] cnt_r    [ctpg_pkg::NUM_TIMERS];
  logic [ctpg_pkg::PERIOD_W-1:0] cnt_nxt  [ctpg_pkg::NUM_TIMERS];
  logic [ctpg_pkg::NUM_TIMERS-1:0] due_r, due_nxt;
  logic [ctpg_pkg::NUM_TIMERS-1:0] upd;
  logic [ctpg_pkg::PERIOD_W-1:0]   cnt_inc;
  logic                            chain;

  // Decode period writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctpg_pkg::NUM_TIMERS; i++) begin
        period_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ctpg_pkg::CFG_TIMER_A: period_r[0] <= cfg_wdata;
        ctpg_pkg::CFG_TIMER_B: period_r[1] <= cfg_wdata;
        ctpg_pkg::CFG_TIMER_C: period_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Update timers in order, halting at the first zero period
  always_comb begin
    cnt_inc = '0;
    chain   = ctl.base;
    for (int i = 0; i < ctpg_pkg::NUM_TIMERS; i++) begin
      chain      = chain && (period_r[i] != '0) && (i < ctpg_pkg::CUSTOM_TIMERS);
      upd[i]     = chain;
      cnt_inc    = cnt_r[i] + 1'b1;
      cnt_nxt[i] = cnt_r[i];
      due_nxt[i] = due_r[i];
      if (upd[i]) begin
        due_nxt[i] = (cnt_inc == period_r[i]);
        cnt_nxt[i] = due_nxt[i] ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r <= '0;
      for (int i = 0; i < ctpg_pkg::NUM_TIMERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (ctl.step) begin
      due_r <= due_nxt;
      for (int i = 0; i < ctpg_pkg::NUM_TIMERS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign due = due_nxt;

  a_due_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (due_r[0] |-> cnt_r[0] == '0) and (due_r[2] |-> cnt_r[2] == '0))
    else $error("due timer did not restart its counter");

  a_chain_order: assert property (@(posedge clk) disable iff (!rst_n)
    (upd[2] |-> upd[1]) and (upd[1] |-> upd[0]))
    else $error("later timer updated past a disabled one");

endmodule

>>> hdl/ctpg_out_reg.sv
// Result register: packs one result word and holds it until taken.
// Depends on ctpg_pkg.
module ctpg_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  ctpg_pkg::ctpg_pulse_t             pulse,
  input  logic [ctpg_pkg::NUM_TIMERS-1:0]   due,
  output logic                              advance,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctpg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                             out_valid_r;
  logic [ctpg_pkg::OUT_TDATA_W-1:0] data_r;
  logic [ctpg_pkg::OUT_TDATA_W-1:0] data_nxt;

  // Move on when the register is empty or its word is taken
  assign advance    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;

  // Pack fields from bit 0 upward
  assign data_nxt = {5'b0, due, pulse.polls_per_second,
                     pulse.tick_5min, pulse.tick_1min, pulse.tick_5s, pulse.toggle_1s,
                     pulse.tick_1s, pulse.tick_250ms, pulse.tick_100ms, pulse.tick_base};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> verif/cascaded_timebase_pulse_generator_unit_tb.sv
// Self-checking testbench for the cascaded timebase pulse generator.
// Polls are streamed in under random stalls, each result word is predicted from a
// shadow timebase and compared field by field. Depends on ctpg_pkg and the RTL.
module cascaded_timebase_pulse_generator_unit_tb;

  typedef logic [ctpg_pkg::PERIOD_W-1:0] period_t;

  localparam logic [31:0]                    BASE_US         = 32'd2500;
  localparam int                             TICKS_PER_100MS = 40;
  localparam int                             TICKS_PER_250MS = 100;
  localparam int                             TENTHS_PER_SEC  = 10;
  localparam int                             SECS_PER_5S     = 5;
  localparam int                             SECS_PER_MIN    = 60;
  localparam int                             SECS_PER_5MIN   = 300;
  localparam logic [ctpg_pkg::RATE_W-1:0]    RATE_CAP        = {ctpg_pkg::RATE_W{1'b1}};
  localparam logic [ctpg_pkg::CFG_IDX_W-1:0] CFG_UNUSED      = 2'd3;
  localparam int                             LATENCY_PAD     = 4;
  localparam int                             HOLD_CYCLES     = 200;
  localparam int                             STALL_LIMIT     = 2000;
  localparam int                             MAX_SHOWN       = 40;

  // One result word, lowest field last
  typedef struct packed {
    logic [4:0]                  pad;
    logic                        due_c;
    logic                        due_b;
    logic                        due_a;
    logic [ctpg_pkg::RATE_W-1:0] rate;
    logic                        t5min;
    logic                        t1min;
    logic                        t5s;
    logic                        toggle;
    logic                        t1s;
    logic                        t250;
    logic                        t100;
    logic                        base;
  } pulse_word_t;

  typedef enum {STAMP_TICK, STAMP_QUIET, STAMP_BACK, STAMP_WILD, STAMP_EDGE} stamp_kind_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [ctpg_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [ctpg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             cfg_wr_en;
  logic [ctpg_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [ctpg_pkg::PERIOD_W-1:0]    cfg_wdata;

  // Shadow timebase state
  logic [31:0]                 seen_stamp;
  logic [5:0]                  div_100ms;
  logic [6:0]                  div_250ms;
  logic [3:0]                  div_1s;
  logic [2:0]                  div_5s;
  logic [5:0]                  div_1min;
  logic [8:0]                  div_5min;
  logic                        sec_level;
  logic [ctpg_pkg::RATE_W-1:0] polls_this_sec;
  logic [ctpg_pkg::RATE_W-1:0] polls_last_sec;
  period_t                     timer_period [ctpg_pkg::NUM_TIMERS];
  period_t                     timer_count  [ctpg_pkg::NUM_TIMERS];
  logic                        timer_due    [ctpg_pkg::NUM_TIMERS];

  pulse_word_t pending_words [$];

  int mismatches    = 0;
  int polls_sent    = 0;
  int words_seen    = 0;
  int base_ticks    = 0;
  int sec_pulses    = 0;
  int min5_pulses   = 0;
  int timer_hits    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int send_calm     = 0;
  int quiet_cycles  = 0;

  cascaded_timebase_pulse_generator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the shadow timebase by one poll and return the word it should produce
  function automatic pulse_word_t poll_outcome(input logic [31:0] now);
    pulse_word_t w;
    logic        tick;
    logic        live;
    logic        hit100, hit250, hit1s, hit5s, hit1m, hit5m;
    int          i;
    w      = '0;
    hit100 = 1'b0;
    hit250 = 1'b0;
    hit1s  = 1'b0;
    hit5s  = 1'b0;
    hit1m  = 1'b0;
    hit5m  = 1'b0;
    if (polls_this_sec != RATE_CAP) polls_this_sec = polls_this_sec + 1'b1;
    tick = ((now - seen_stamp) >= BASE_US) || (now < seen_stamp);
    if (tick) begin
      seen_stamp = now;
      base_ticks++;
      // update timers in order, stopping at the first zero period
      live = 1'b1;
      for (i = 0; i < ctpg_pkg::NUM_TIMERS; i++) begin
        if (i >= ctpg_pkg::CUSTOM_TIMERS || timer_period[i] == '0) live = 1'b0;
        if (live) begin
          timer_count[i] = timer_count[i] + 1'b1;
          if (timer_count[i] == timer_period[i]) begin
            timer_due[i]   = 1'b1;
            timer_count[i] = '0;
            timer_hits++;
          end else begin
            timer_due[i] = 1'b0;
          end
        end
      end
      // cascade: 100 ms feeds the seconds, which feed 5 s, 1 min and 5 min
      if (div_100ms == TICKS_PER_100MS - 1) begin
        div_100ms = '0;
        hit100    = 1'b1;
      end else begin
        div_100ms = div_100ms + 1'b1;
      end
      if (hit100) begin
        if (div_1s == TENTHS_PER_SEC - 1) begin
          div_1s = '0;
          hit1s  = 1'b1;
        end else begin
          div_1s = div_1s + 1'b1;
        end
      end
      if (hit1s) begin
        sec_pulses++;
        sec_level      = ~sec_level;
        polls_last_sec = polls_this_sec;
        polls_this_sec = '0;
        if (div_5s == SECS_PER_5S - 1) begin
          div_5s = '0;
          hit5s  = 1'b1;
        end else begin
          div_5s = div_5s + 1'b1;
        end
        if (div_1min == SECS_PER_MIN - 1) begin
          div_1min = '0;
          hit1m    = 1'b1;
        end else begin
          div_1min = div_1min + 1'b1;
        end
        if (div_5min == SECS_PER_5MIN - 1) begin
          div_5min = '0;
          hit5m    = 1'b1;
          min5_pulses++;
        end else begin
          div_5min = div_5min + 1'b1;
        end
      end
      if (div_250ms == TICKS_PER_250MS - 1) begin
        div_250ms = '0;
        hit250    = 1'b1;
      end else begin
        div_250ms = div_250ms + 1'b1;
      end
    end
    w.base   = tick;
    w.t100   = hit100;
    w.t250   = hit250;
    w.t1s    = hit1s;
    w.toggle = sec_level;
    w.t5s    = hit5s;
    w.t1min  = hit1m;
    w.t5min  = hit5m;
    w.rate   = polls_last_sec;
    w.due_a  = (ctpg_pkg::CUSTOM_TIMERS > 0) ? timer_due[0] : 1'b0;
    w.due_b  = (ctpg_pkg::CUSTOM_TIMERS > 1) ? timer_due[1] : 1'b0;
    w.due_c  = (ctpg_pkg::CUSTOM_TIMERS > 2) ? timer_due[2] : 1'b0;
    return w;
  endfunction

  // Gap length: mostly none, some short, a few long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stamp_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return STAMP_TICK;
    if (r < 85) return STAMP_QUIET;
    if (r < 90) return STAMP_BACK;
    if (r < 95) return STAMP_WILD;
    return STAMP_EDGE;
  endfunction

  // Timestamp relative to the last base tick of the shadow model, or fully random
  function automatic logic [31:0] pick_stamp(input stamp_kind_t kind);
    case (kind)
      STAMP_TICK:  return seen_stamp + BASE_US + $urandom_range(0, 2500);
      STAMP_QUIET: return seen_stamp + $urandom_range(0, 2499);
      STAMP_BACK:  return seen_stamp - $urandom_range(1, 6000);
      STAMP_WILD:  return $urandom;
      default:     return seen_stamp + ($urandom_range(0, 1) ? BASE_US : BASE_US - 1);
    endcase
  endfunction

  function automatic period_t pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return {ctpg_pkg::PERIOD_W{1'b1}};
    if (r < 28) return period_t'($urandom_range(0, 16383));
    return period_t'($urandom_range(1, 12));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [ctpg_pkg::RATE_W-1:0] got,
                             input logic [ctpg_pkg::RATE_W-1:0] want);
    if (got !== want)
      note_mismatch($sformatf("word %0d: %s is %0h, expected %0h", words_seen, name, got,
                              want));
  endtask

  // Offer one poll word; the next call keeps tvalid high when it wants no gap
  task automatic send_poll(input logic [31:0] now, input bit eager);
    int gap;
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(16, 64);
    gap = (eager || send_calm > 0) ? 0 : idle_span();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= now;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_words.push_back(poll_outcome(now));
    polls_sent++;
  endtask

  // Stop offering and wait until every word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ctpg_pkg::CFG_IDX_W-1:0] idx, input period_t v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx < ctpg_pkg::NUM_TIMERS) timer_period[idx] = v;
    @(posedge clk);
  endtask

  // Reprogram all periods while idle, plus a write to the unused index
  task automatic program_timers(input period_t a, input period_t b, input period_t c);
    wait_drained();
    write_reg(ctpg_pkg::CFG_TIMER_A, a);
    write_reg(ctpg_pkg::CFG_TIMER_B, b);
    write_reg(ctpg_pkg::CFG_TIMER_C, c);
    write_reg(CFG_UNUSED, period_t'($urandom_range(0, 16383)));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_ticks(input int n);
    int k;
    for (k = 0; k < n; k++)
      send_poll(pick_stamp(($urandom_range(0, 19) == 0) ? STAMP_QUIET : STAMP_TICK), 1'b0);
  endtask

  // Threshold, repeated stamp, backward step and wrap of the timestamp
  task automatic test_tick_threshold();
    send_poll(32'd0, 1'b0);
    send_poll(32'd2499, 1'b0);
    send_poll(32'd2500, 1'b0);
    send_poll(32'd2500, 1'b0);
    send_poll(32'd4999, 1'b0);
    send_poll(32'd5000, 1'b0);
    send_poll(32'd4000, 1'b0);
    send_poll(32'hFFFF_FFFF, 1'b0);
    send_poll(32'd0, 1'b0);
    send_poll(32'd2499, 1'b0);
    wait_drained();
  endtask

  // Extreme periods, flags held on quiet polls, zero period cutting off later timers
  task automatic test_timer_extremes();
    program_timers(14'd1, 14'd2, {ctpg_pkg::PERIOD_W{1'b1}});
    repeat (5) send_poll(pick_stamp(STAMP_TICK), 1'b0);
    send_poll(pick_stamp(STAMP_QUIET), 1'b0);
    program_timers(14'd2, 14'd0, 14'd5);
    repeat (4) send_poll(pick_stamp(STAMP_TICK), 1'b0);
    program_timers(14'd0, 14'd3, 14'd3);
    repeat (3) send_poll(pick_stamp(STAMP_TICK), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int phase;
    int n;
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 0)
        program_timers({ctpg_pkg::PERIOD_W{1'b1}}, {ctpg_pkg::PERIOD_W{1'b1}},
                       {ctpg_pkg::PERIOD_W{1'b1}});
      else if (phase == 1) program_timers(14'd1, 14'd1, 14'd1);
      else program_timers(pick_period(), pick_period(), pick_period());
      for (n = 0; n < 150; n++) send_poll(pick_stamp(pick_kind()), 1'b0);
    end
    wait_drained();
  endtask

  // Long receiver hold while polls keep coming, then a full drain before resuming
  task automatic test_input_backpressure();
    int n;
    hold_requests++;
    for (n = 0; n < 24; n++) send_poll(pick_stamp(STAMP_TICK), 1'b1);
    wait_drained();
    for (n = 0; n < 24; n++) send_poll(pick_stamp(pick_kind()), 1'b0);
    wait_drained();
  endtask

  // Long runs of base ticks to carry the cascade through the one second pulses
  task automatic test_cascade_depth();
    program_timers({ctpg_pkg::PERIOD_W{1'b1}}, 14'd40, 14'd1);
    run_ticks(450);
    // first period now well below its count: it must wrap before matching
    program_timers(14'd3, 14'd0, 14'd9);
    run_ticks(150);
    program_timers(14'd5, 14'd7, 14'd11);
    run_ticks(200);
    program_timers(14'd0, 14'd2, 14'd2);
    run_ticks(50);
    wait_drained();
  endtask

  // Result side: random stalls, calm stretches and requested long holds
  initial begin
    int stall;
    int calm;
    stall      = 0;
    calm       = 0;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_served != hold_requests) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        if (stall > 0) begin
          stall--;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if (calm > 0) calm--;
          else if ($urandom_range(0, 19) == 0) calm = $urandom_range(16, 64);
          else stall = idle_span();
        end
        @(posedge clk);
      end
    end
  end

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin : result_check
    pulse_word_t got;
    pulse_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      words_seen++;
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("word %0d arrived with no poll waiting", words_seen));
      end else begin
        want = pending_words.pop_front();
        check_field("tick_base", got.base, want.base);
        check_field("tick_100ms", got.t100, want.t100);
        check_field("tick_250ms", got.t250, want.t250);
        check_field("tick_1s", got.t1s, want.t1s);
        check_field("toggle_1s", got.toggle, want.toggle);
        check_field("tick_5s", got.t5s, want.t5s);
        check_field("tick_1min", got.t1min, want.t1min);
        check_field("tick_5min", got.t5min, want.t5min);
        check_field("polls_per_second", got.rate, want.rate);
        check_field("timer_a_due", got.due_a, want.due_a);
        check_field("timer_b_due", got.due_b, want.due_b);
        check_field("timer_c_due", got.due_c, want.due_c);
        check_field("padding", got.pad, want.pad);
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cascaded_timebase_pulse_generator_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    seen_stamp     = '0;
    div_100ms      = '0;
    div_250ms      = '0;
    div_1s         = '0;
    div_5s         = '0;
    div_1min       = '0;
    div_5min       = '0;
    sec_level      = 1'b0;
    polls_this_sec = '0;
    polls_last_sec = '0;
    for (i = 0; i < ctpg_pkg::NUM_TIMERS; i++) begin
      timer_period[i] = '0;
      timer_count[i]  = '0;
      timer_due[i]    = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tick_threshold();
    test_timer_extremes();
    test_random_mix();
    test_input_backpressure();
    test_cascade_depth();
    wait_drained();

    if (pending_words.size() != 0)
      note_mismatch($sformatf("%0d predicted words never arrived", pending_words.size()));
    $display("Covered %0d polls, %0d words checked, %0d base ticks, %0d one-second pulses,",
             polls_sent, words_seen, base_ticks, sec_pulses);
    $display("%0d five-minute pulses and %0d timer matches; %0d mismatches.",
             min5_pulses, timer_hits, mismatches);
    if (mismatches == 0) begin
      $display("cascaded_timebase_pulse_generator_unit regression: pass");
    end else begin
      $display("cascaded_timebase_pulse_generator_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ctpg_pkg.sv
hdl/ctpg_in_reg.sv
hdl/ctpg_timebase.sv
hdl/ctpg_timers.sv
hdl/ctpg_out_reg.sv
hdl/cascaded_timebase_pulse_generator_unit.sv
verif/cascaded_timebase_pulse_generator_unit_tb.sv
